// ----- rtl/core/skt_pkg.sv -----
// Shared types and constants of the sorted key table.
package skt_pkg;

  // Fixed field widths
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned IDX_W    = 16;
  localparam int unsigned STATUS_W = 3;

  // Request opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd4;

  // Update command broadcast to every cell
  typedef struct packed {
    logic ins;   // open a gap at the insertion point and write the new entry
    logic rep;   // overwrite the payload of the matching entry
  } skt_apply_t;

endpackage

// ----- rtl/core/sorted_key_table.sv -----
// Top level of the sorted key table: request control, cell chain, result register.
//
// A table of entries kept in ascending order of a 64-bit key, one entry per cell.
// Input channel (in_*): one request per accept, opcode 0 inserts or replaces,
// opcode 1 looks a key up. Result channel (out_*): exactly one result per request,
// with status, slot position, payload and the entry count after the request.
// Both channels use valid/stall; an item moves on a clock edge with valid high
// and stall low.
// Sequence: one request at a time; from accept to result in the output register
// it passes a compare state (S_CMP) in which every cell compares its key at once,
// the states S_SUM1 and S_SUM2 through the registered OR tree that gathers the
// insertion-point cell, and a final state (S_DONE) in which the result is loaded
// and the chain shifts in one step. The next request is accepted in the cycle
// after the result is loaded, also while that result still waits.
// If the receiver stalls, the finished result holds in the output register and
// the following request waits in its final cycle until the register is free.
// Reset (synchronous, active low) empties the table by clearing the count; slot
// contents are left as they are and read only below the count.
// An insert is rejected when count + 1 reaches the depth, replace included.
module sorted_key_table #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned BANK_COUNT  = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  logic [skt_pkg::KEY_W-1:0]    in_key,
  input  logic [$clog2(BANK_COUNT)-1:0] in_bank_id,
  input  logic [skt_pkg::IDX_W-1:0]    in_entry_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [skt_pkg::STATUS_W-1:0] out_status,
  output logic [$clog2(TABLE_DEPTH)-1:0] out_position,
  output logic [$clog2(BANK_COUNT)-1:0] out_found_bank,
  output logic [skt_pkg::IDX_W-1:0]    out_found_index,
  output logic [$clog2(TABLE_DEPTH)-1:0] out_entry_count
);

  localparam int unsigned PW = $clog2(TABLE_DEPTH);
  localparam int unsigned BW = $clog2(BANK_COUNT);
  localparam int unsigned TW = 1 + BW + skt_pkg::IDX_W + PW;
  localparam logic [PW:0] DEPTH_C = (PW + 1)'(TABLE_DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_CMP, S_SUM1, S_SUM2, S_DONE} state_t;

  state_t                       state_r;
  logic                         req_op_r;
  logic [skt_pkg::KEY_W-1:0]    req_key_r;
  logic [BW-1:0]                req_bank_r;
  logic [skt_pkg::IDX_W-1:0]    req_idx_r;
  logic [PW-1:0]                count_r;
  logic [PW-1:0]                count_nxt;
  logic                         out_valid_r;
  logic [skt_pkg::STATUS_W-1:0] status_r;
  logic [skt_pkg::STATUS_W-1:0] status_nxt;
  logic [PW-1:0]                pos_r;
  logic [PW-1:0]                pos_nxt;
  logic [BW-1:0]                bank_r;
  logic [BW-1:0]                bank_nxt;
  logic [skt_pkg::IDX_W-1:0]    idx_r;
  logic [skt_pkg::IDX_W-1:0]    idx_nxt;

  logic                         in_take;
  logic                         out_free;
  logic                         finish;
  logic                         full;
  logic                         hit;
  logic [PW-1:0]                hit_pos;
  logic [BW-1:0]                hit_bank;
  logic [skt_pkg::IDX_W-1:0]    hit_idx;
  skt_pkg::skt_apply_t          apply;

  logic [TABLE_DEPTH-1:0]          lt_q;
  logic [skt_pkg::KEY_W-1:0]       key_q  [TABLE_DEPTH];
  logic [BW-1:0]                   bank_q [TABLE_DEPTH];
  logic [skt_pkg::IDX_W-1:0]       idx_q  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0][TW-1:0]  taps;
  logic [TW-1:0]                   sum;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign finish   = (state_r == S_DONE) && out_free;

  // Unpack the gathered insertion-point report
  assign hit      = sum[TW-1];
  assign hit_bank = sum[TW-2 -: BW];
  assign hit_idx  = sum[PW + skt_pkg::IDX_W - 1 -: skt_pkg::IDX_W];
  assign hit_pos  = sum[PW-1:0];
  assign full     = ({1'b0, count_r} + (PW + 1)'(1)) >= DEPTH_C;

  // Decide the result and the table update
  always_comb begin
    apply      = '0;
    count_nxt  = count_r;
    status_nxt = skt_pkg::ST_MISSING;
    pos_nxt    = hit_pos;
    bank_nxt   = hit_bank;
    idx_nxt    = hit_idx;
    if (req_op_r == skt_pkg::OP_LOOKUP) begin
      status_nxt = hit ? skt_pkg::ST_FOUND : skt_pkg::ST_MISSING;
    end else if (full) begin
      status_nxt = skt_pkg::ST_FULL;
      pos_nxt    = '0;
      bank_nxt   = '0;
      idx_nxt    = '0;
    end else begin
      bank_nxt = req_bank_r;
      idx_nxt  = req_idx_r;
      if (hit) begin
        status_nxt = skt_pkg::ST_REPLACED;
        apply.rep  = finish;
      end else begin
        status_nxt = skt_pkg::ST_INSERTED;
        apply.ins  = finish;
        count_nxt  = count_r + PW'(1);
      end
    end
  end

  // Sequence the request and hold the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop a taken result unless a new one loads in its place
      if (out_valid_r && !out_stall && !finish) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            state_r <= S_CMP;
          end
        end
        S_CMP:  state_r <= S_SUM1;
        S_SUM1: state_r <= S_SUM2;
        S_SUM2: state_r <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state_r     <= S_IDLE;
            count_r     <= count_nxt;
            out_valid_r <= 1'b1;
            status_r    <= status_nxt;
            pos_r       <= pos_nxt;
            bank_r      <= bank_nxt;
            idx_r       <= idx_nxt;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_op_r   <= in_opcode;
      req_key_r  <= in_key;
      req_bank_r <= in_bank_id;
      req_idx_r  <= in_entry_index;
    end
  end

  // Chain of slots, each fed by its lower neighbor
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic                      lt_in;
    logic [skt_pkg::KEY_W-1:0] key_in;
    logic [BW-1:0]             bank_in;
    logic [skt_pkg::IDX_W-1:0] idx_in;
    if (i == 0) begin : g_head
      assign lt_in   = 1'b1;
      assign key_in  = '0;
      assign bank_in = '0;
      assign idx_in  = '0;
    end else begin : g_link
      assign lt_in   = lt_q[i-1];
      assign key_in  = key_q[i-1];
      assign bank_in = bank_q[i-1];
      assign idx_in  = idx_q[i-1];
    end
    skt_cell #(
      .SLOT(i),
      .PW  (PW),
      .BW  (BW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmp_en   (state_r == S_CMP),
      .req_key  (req_key_r),
      .req_bank (req_bank_r),
      .req_idx  (req_idx_r),
      .count    (count_r),
      .apply    (apply),
      .lt_prev  (lt_in),
      .prev_key (key_in),
      .prev_bank(bank_in),
      .prev_idx (idx_in),
      .lt       (lt_q[i]),
      .key      (key_q[i]),
      .bank     (bank_q[i]),
      .idx      (idx_q[i]),
      .tap      (taps[i])
    );
  end

  skt_or_tree #(
    .N(TABLE_DEPTH),
    .W(TW)
  ) u_tree (
    .clk (clk),
    .data(taps),
    .sum (sum)
  );

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_position    = pos_r;
  assign out_found_bank  = bank_r;
  assign out_found_index = idx_r;
  assign out_entry_count = count_r;

  // Count never reaches the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, count_r} < DEPTH_C)
    else $error("entry count reached table depth");

  // A fresh insert grows the count by one
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    apply.ins |=> count_r == $past(count_r) + PW'(1))
    else $error("insert did not grow the entry count");

  // A matching key always lies below the count
  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && hit) |-> hit_pos < count_r)
    else $error("match reported beyond held entries");

  // Result register loads only from the final state
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result loaded outside final state");

endmodule

// ----- rtl/core/skt_cell.sv -----
// One slot of the sorted table: compare against the request, shift, load.
module skt_cell #(
  parameter int unsigned SLOT = 0,
  parameter int unsigned PW   = 10,
  parameter int unsigned BW   = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cmp_en,
  input  logic [skt_pkg::KEY_W-1:0] req_key,
  input  logic [BW-1:0]             req_bank,
  input  logic [skt_pkg::IDX_W-1:0] req_idx,
  input  logic [PW-1:0]             count,
  input  skt_pkg::skt_apply_t       apply,
  input  logic                      lt_prev,
  input  logic [skt_pkg::KEY_W-1:0] prev_key,
  input  logic [BW-1:0]             prev_bank,
  input  logic [skt_pkg::IDX_W-1:0] prev_idx,
  output logic                      lt,
  output logic [skt_pkg::KEY_W-1:0] key,
  output logic [BW-1:0]             bank,
  output logic [skt_pkg::IDX_W-1:0] idx,
  output logic [1+BW+skt_pkg::IDX_W+PW-1:0] tap
);

  logic                      lt_r;
  logic                      eq_r;
  logic [skt_pkg::KEY_W-1:0] key_r;
  logic [BW-1:0]             bank_r;
  logic [skt_pkg::IDX_W-1:0] idx_r;
  logic                      held;
  logic                      first;

  // Slot holds an entry when it lies below the count
  assign held  = PW'(SLOT) < count;
  // Insertion point: first slot whose key is not below the request key
  assign first = !lt_r && lt_prev;

  // Capture the compare result for this request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (cmp_en) begin
      lt_r <= held && (key_r < req_key);
      eq_r <= held && (key_r == req_key);
    end
  end

  // Load the new entry, shift up from the neighbor, or replace the payload
  always_ff @(posedge clk) begin
    if (apply.ins) begin
      if (first) begin
        key_r  <= req_key;
        bank_r <= req_bank;
        idx_r  <= req_idx;
      end else if (!lt_r) begin
        key_r  <= prev_key;
        bank_r <= prev_bank;
        idx_r  <= prev_idx;
      end
    end else if (apply.rep && first) begin
      bank_r <= req_bank;
      idx_r  <= req_idx;
    end
  end

  // Report hit, payload and slot number from the insertion point only
  always_comb begin
    tap = '0;
    if (first) begin
      tap = {eq_r, (eq_r ? bank_r : BW'(0)), (eq_r ? idx_r : skt_pkg::IDX_W'(0)), PW'(SLOT)};
    end
  end

  assign lt   = lt_r;
  assign key  = key_r;
  assign bank = bank_r;
  assign idx  = idx_r;

endmodule

// ----- rtl/core/skt_or_tree.sv -----
// Two-stage registered OR tree that collects the one active cell report.
module skt_or_tree #(
  parameter int unsigned N = 1024,
  parameter int unsigned W = 34
) (
  input  logic                clk,
  input  logic [N-1:0][W-1:0] data,
  output logic [W-1:0]        sum
);

  localparam int unsigned G  = 32;
  localparam int unsigned NG = (N + G - 1) / G;

  logic [NG-1:0][W-1:0] grp_r;
  logic [NG-1:0][W-1:0] grp_nxt;
  logic [W-1:0]         sum_r;
  logic [W-1:0]         sum_nxt;

  // Fold each group of cells
  always_comb begin
    grp_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      for (int k = 0; k < G; k++) begin
        if (g * G + k < N) begin
          grp_nxt[g] = grp_nxt[g] | data[g * G + k];
        end
      end
    end
  end

  // Fold the group results
  always_comb begin
    sum_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      sum_nxt = sum_nxt | grp_r[g];
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
    sum_r <= sum_nxt;
  end

  assign sum = sum_r;

endmodule

// ----- tb/sorted_key_table_tb.sv -----
// Self-checking testbench for the sorted key table: directed requests, random mixed requests.
module sorted_key_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH     = 1024;
  localparam int unsigned BANK_COUNT      = 128;
  localparam int unsigned POS_W           = $clog2(TABLE_DEPTH);
  localparam int unsigned BANK_W          = $clog2(BANK_COUNT);
  localparam int unsigned RANDOM_REQUESTS = 880;
  localparam int unsigned LONG_HOLD       = 300;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned CYCLE_LIMIT     = 400000;

  typedef struct packed {
    logic [skt_pkg::STATUS_W-1:0] status;
    logic [POS_W-1:0]             position;
    logic [BANK_W-1:0]            bank;
    logic [skt_pkg::IDX_W-1:0]    index;
    logic [POS_W-1:0]             entries;
  } table_result_t;

  typedef struct {
    logic                      op;
    logic [skt_pkg::KEY_W-1:0] key;
    logic [BANK_W-1:0]         bank;
    logic [skt_pkg::IDX_W-1:0] index;
    bit                        typed;
    table_result_t             want;
  } request_row_t;

  typedef enum {KEY_FRESH, KEY_HELD, KEY_NEAR, KEY_EDGE} key_kind_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         in_opcode = skt_pkg::OP_INSERT;
  logic [skt_pkg::KEY_W-1:0]    in_key = '0;
  logic [BANK_W-1:0]            in_bank_id = '0;
  logic [skt_pkg::IDX_W-1:0]    in_entry_index = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [skt_pkg::STATUS_W-1:0] out_status;
  logic [POS_W-1:0]             out_position;
  logic [BANK_W-1:0]            out_found_bank;
  logic [skt_pkg::IDX_W-1:0]    out_found_index;
  logic [POS_W-1:0]             out_entry_count;

  // Predicted table contents, ascending by key
  logic [skt_pkg::KEY_W-1:0] table_keys [TABLE_DEPTH];
  logic [BANK_W-1:0]         table_banks [TABLE_DEPTH];
  logic [skt_pkg::IDX_W-1:0] table_indices [TABLE_DEPTH];
  int unsigned               table_fill = 0;

  table_result_t awaited_results[$];
  request_row_t  directed_rows[$];
  int unsigned   err_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   results_seen = 0;
  bit            quiet_run = 1'b0;

  sorted_key_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .BANK_COUNT (BANK_COUNT)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_key         (in_key),
    .in_bank_id     (in_bank_id),
    .in_entry_index (in_entry_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_position   (out_position),
    .out_found_bank (out_found_bank),
    .out_found_index(out_found_index),
    .out_entry_count(out_entry_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    err_count++;
    $display("ERROR at cycle %0d: %s", cycle_count, what);
  endtask

  function automatic int unsigned draw_wait();
    return quiet_run ? 0 : $urandom_range(0, 6);
  endfunction

  // Apply one request to the predicted table and return its result
  function automatic table_result_t apply_request(logic op, logic [skt_pkg::KEY_W-1:0] key,
                                                  logic [BANK_W-1:0] bank,
                                                  logic [skt_pkg::IDX_W-1:0] index);
    table_result_t res;
    int unsigned   lo;
    int unsigned   hi;
    int unsigned   mid;
    bit            hit;
    res = '0;
    // reject inserts once count + 1 reaches the depth, replace included
    if (op == skt_pkg::OP_INSERT && table_fill + 1 >= TABLE_DEPTH) begin
      res.status  = skt_pkg::ST_FULL;
      res.entries = table_fill[POS_W-1:0];
      return res;
    end
    // lower bound of the key among held entries
    lo = 0;
    hi = table_fill;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (table_keys[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    hit = (lo < table_fill) && (table_keys[lo] == key);
    res.position = lo[POS_W-1:0];
    if (op == skt_pkg::OP_LOOKUP) begin
      res.status = hit ? skt_pkg::ST_FOUND : skt_pkg::ST_MISSING;
      if (hit) begin
        res.bank  = table_banks[lo];
        res.index = table_indices[lo];
      end
    end else begin
      // open a gap for a new key
      if (!hit) begin
        for (int s = table_fill; s > lo; s--) begin
          table_keys[s]    = table_keys[s-1];
          table_banks[s]   = table_banks[s-1];
          table_indices[s] = table_indices[s-1];
        end
        table_keys[lo] = key;
        table_fill++;
      end
      table_banks[lo]   = bank;
      table_indices[lo] = index;
      res.status = hit ? skt_pkg::ST_REPLACED : skt_pkg::ST_INSERTED;
      res.bank   = bank;
      res.index  = index;
    end
    res.entries = table_fill[POS_W-1:0];
    return res;
  endfunction

  function automatic logic [skt_pkg::KEY_W-1:0] pick_key(key_kind_t kind);
    logic [skt_pkg::KEY_W-1:0] k;
    int unsigned               slot;
    k = {$urandom, $urandom};
    if (table_fill != 0 && (kind == KEY_HELD || kind == KEY_NEAR)) begin
      slot = $urandom_range(0, table_fill - 1);
      k = table_keys[slot];
      if (kind == KEY_NEAR) k = $urandom_range(0, 1) ? k + 64'd1 : k - 64'd1;
    end else if (kind == KEY_EDGE) begin
      case ($urandom_range(0, 4))
        0: k = '0;
        1: k = '1;
        2: k = 64'd1;
        3: k = {1'b1, 63'd0};
        default: k = {1'b0, {63{1'b1}}};
      endcase
    end
    return k;
  endfunction

  task automatic add_row(logic op, logic [skt_pkg::KEY_W-1:0] key, logic [BANK_W-1:0] bank,
                         logic [skt_pkg::IDX_W-1:0] index, bit typed,
                         logic [skt_pkg::STATUS_W-1:0] st,
                         int unsigned pos, int unsigned bk, int unsigned ix,
                         int unsigned cnt);
    request_row_t row;
    row.op            = op;
    row.key           = key;
    row.bank          = bank;
    row.index         = index;
    row.typed         = typed;
    row.want.status   = st;
    row.want.position = pos[POS_W-1:0];
    row.want.bank     = bk[BANK_W-1:0];
    row.want.index    = ix[skt_pkg::IDX_W-1:0];
    row.want.entries  = cnt[POS_W-1:0];
    directed_rows.push_back(row);
  endtask

  // Offer one request, hold it until accepted, then record its expected result
  task automatic send_request(logic op, logic [skt_pkg::KEY_W-1:0] key,
                              logic [BANK_W-1:0] bank,
                              logic [skt_pkg::IDX_W-1:0] index, bit typed,
                              table_result_t want);
    int unsigned   gap;
    table_result_t predicted;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_key         <= key;
    in_bank_id     <= bank;
    in_entry_index <= index;
    do @(posedge clk); while (in_stall);
    predicted = apply_request(op, key, bank, index);
    awaited_results.push_back(typed ? want : predicted);
  endtask

  // Request source
  initial begin : request_source
    logic [skt_pkg::KEY_W-1:0] k;
    logic                      op;
    int unsigned               sent;
    int unsigned               r;
    key_kind_t                 kind;

    // Empty-table lookups, extremes, replace, then a few mixed rows
    add_row(skt_pkg::OP_LOOKUP, '0, '0, '0, 1, skt_pkg::ST_MISSING, 0, 0, 0, 0);
    add_row(skt_pkg::OP_LOOKUP, '1, '1, '1, 1, skt_pkg::ST_MISSING, 0, 0, 0, 0);
    add_row(skt_pkg::OP_INSERT, {1'b1, 63'd0}, 7'h7f, 16'hffff, 1,
            skt_pkg::ST_INSERTED, 0, 127, 16'hffff, 1);
    add_row(skt_pkg::OP_INSERT, '0, '0, '0, 1, skt_pkg::ST_INSERTED, 0, 0, 0, 2);
    add_row(skt_pkg::OP_INSERT, '1, 7'd1, 16'd1, 1, skt_pkg::ST_INSERTED, 2, 1, 1, 3);
    add_row(skt_pkg::OP_INSERT, {1'b1, 63'd0}, 7'd5, 16'h1234, 1,
            skt_pkg::ST_REPLACED, 1, 5, 16'h1234, 3);
    add_row(skt_pkg::OP_LOOKUP, {1'b1, 63'd0}, '0, '0, 1,
            skt_pkg::ST_FOUND, 1, 5, 16'h1234, 3);
    add_row(skt_pkg::OP_LOOKUP, '1, '0, '0, 1, skt_pkg::ST_FOUND, 2, 1, 1, 3);
    add_row(skt_pkg::OP_LOOKUP, 64'd1, '0, '0, 1, skt_pkg::ST_MISSING, 1, 0, 0, 3);
    add_row(skt_pkg::OP_LOOKUP, 64'hffff_ffff_ffff_fffe, '0, '0, 1,
            skt_pkg::ST_MISSING, 2, 0, 0, 3);
    add_row(skt_pkg::OP_INSERT, 64'h7fff_ffff_ffff_ffff, 7'h55, 16'haaaa, 0,
            skt_pkg::ST_INSERTED, 0, 0, 0, 0);
    add_row(skt_pkg::OP_INSERT, '0, 7'h2a, 16'h5555, 0, skt_pkg::ST_INSERTED, 0, 0, 0, 0);
    add_row(skt_pkg::OP_INSERT, 64'hffff_ffff_ffff_fffe, '0, 16'hffff, 0,
            skt_pkg::ST_INSERTED, 0, 0, 0, 0);
    add_row(skt_pkg::OP_INSERT, 64'h5555_5555_5555_5555, 7'h7f, '0, 0,
            skt_pkg::ST_INSERTED, 0, 0, 0, 0);
    add_row(skt_pkg::OP_INSERT, 64'haaaa_aaaa_aaaa_aaaa, '0, 16'hffff, 0,
            skt_pkg::ST_INSERTED, 0, 0, 0, 0);
    add_row(skt_pkg::OP_LOOKUP, '0, '0, '0, 0, skt_pkg::ST_INSERTED, 0, 0, 0, 0);
    add_row(skt_pkg::OP_LOOKUP, 64'haaaa_aaaa_aaaa_aaaa, '1, '1, 0,
            skt_pkg::ST_INSERTED, 0, 0, 0, 0);
    add_row(skt_pkg::OP_LOOKUP, 64'h5555_5555_5555_5554, '0, '0, 0,
            skt_pkg::ST_INSERTED, 0, 0, 0, 0);
    add_row(skt_pkg::OP_LOOKUP, 64'h7fff_ffff_ffff_ffff, '0, '0, 0,
            skt_pkg::ST_INSERTED, 0, 0, 0, 0);
    add_row(skt_pkg::OP_LOOKUP, 64'hffff_ffff_ffff_fffe, '0, '0, 0,
            skt_pkg::ST_INSERTED, 0, 0, 0, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].bank,
                   directed_rows[i].index, directed_rows[i].typed, directed_rows[i].want);

    // Mostly new keys, with lookups of held, neighboring and extreme keys
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      if (sent % 40 == 0) quiet_run = ($urandom_range(0, 4) == 0);
      r  = $urandom_range(0, 99);
      op = (r < ((table_fill < TABLE_DEPTH - 1) ? 88 : 50)) ?
           skt_pkg::OP_INSERT : skt_pkg::OP_LOOKUP;
      r  = $urandom_range(0, 9);
      if (op == skt_pkg::OP_INSERT)
        kind = (r < 8) ? KEY_FRESH : (r == 8) ? KEY_HELD : KEY_EDGE;
      else
        kind = (r < 5) ? KEY_HELD : (r < 7) ? KEY_NEAR : (r == 7) ? KEY_EDGE : KEY_FRESH;
      k = pick_key(kind);
      send_request(op, k, BANK_W'($urandom), skt_pkg::IDX_W'($urandom), 0, '0);
      sent++;
    end
    in_valid <= 1'b0;
    quiet_run = 1'b0;

    // Drain outstanding results, then watch for strays
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Result sink: random stalls, two long hold-offs, field-by-field compare
  initial begin : result_sink
    int unsigned   hold;
    table_result_t got;
    table_result_t want;
    string         bad;
    wait (rst_n === 1'b1);
    forever begin
      hold = (results_seen == 200 || results_seen == 600) ? LONG_HOLD : draw_wait();
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      results_seen++;
      got.status   = out_status;
      got.position = out_position;
      got.bank     = out_found_bank;
      got.index    = out_found_index;
      got.entries  = out_entry_count;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result %0d with no request outstanding", results_seen));
      end else begin
        want = awaited_results.pop_front();
        bad = "";
        if (got.status !== want.status) bad = {bad, " status"};
        if (got.position !== want.position) bad = {bad, " position"};
        if (got.bank !== want.bank) bad = {bad, " found_bank"};
        if (got.index !== want.index) bad = {bad, " found_index"};
        if (got.entries !== want.entries) bad = {bad, " entry_count"};
        if (bad.len() != 0)
          report_mismatch($sformatf({"result %0d wrong%s: ",
            "got st=%0d pos=%0d bank=%0d idx=%h cnt=%0d, ",
            "want st=%0d pos=%0d bank=%0d idx=%h cnt=%0d"},
            results_seen, bad, got.status, got.position, got.bank, got.index, got.entries,
            want.status, want.position, want.bank, want.index, want.entries));
      end
    end
  end

endmodule
